[hw/rtl/wkts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wkts_pkg
// shared types and constants of the weighted key tally with sort
// ----------------------------------------------------------------------------
package wkts_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int WGT_W    = 48;
    localparam int POS_W    = 6;
    localparam int TOT_W    = 7;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_SORT   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_LOAD    = 3'd1,  // latch item, reset scan index
        CMD_SCAN    = 3'd2,  // compare entry at scan index, advance
        CMD_WRITE   = 3'd3,  // write add result, present it
        CMD_REPORT  = 3'd4,  // present lookup/clear/full result
        CMD_SORTSTP = 3'd5,  // one selection-sort compare step
        CMD_SORTSWP = 3'd6,  // swap min into place, advance outer
        CMD_EMIT    = 3'd7   // present sorted entry
    } t_cmd;

    typedef struct packed {
        logic    hit;        // key matched during scan
        logic    match;      // entry on the read port matches the key
        logic    scan_done;  // scan index reached entry count
        logic    full;
        logic    inner_done;
        logic    outer_done;
        logic    swap_done;  // last step of the swap
        logic    sort_done;  // current outer pass is the final one
        logic    emit_last;
        logic    empty;
        t_action action;
    } t_status;

endpackage
`default_nettype wire

[hw/rtl/weighted_key_tally_sort_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_key_tally_sort_unit
// table of keys with saturating accumulated weights, lookup, clear and sort
// ----------------------------------------------------------------------------
// One item is handled at a time; every item is first taken in and then decoded.
// Add and lookup then scan the stored entries through the single memory port.
// Sort is a selection sort over the memory port, and each sorted entry is then
// emitted in turn. Each result waits in the output register until taken, which
// holds off input.
module weighted_key_tally_sort_unit import wkts_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [87:0]  s_axis_tdata,  // action, key, weight_in, zero pad
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,  // key_out, weight_out, position,
                                             // entry_total, zero pad
    output logic [1:0]        m_axis_tuser,  // status, found
    output logic              m_axis_tlast
);
    t_cmd         cmd;
    t_status      status;
    logic         rd_phase;
    logic [94:0]  res;

    wkts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(status), .o_cmd(cmd), .o_rd_phase(rd_phase));

    wkts_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_rd_phase(rd_phase),
        .i_item(s_axis_tdata[81:0]), .o_status(status), .o_result(res),
        .o_last(m_axis_tlast));

    assign m_axis_tuser = res[1:0];
    assign m_axis_tdata = {{(96-93){1'b0}}, res[94:2]};
endmodule
`default_nettype wire

[hw/rtl/wkts_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wkts_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module wkts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[hw/rtl/wkts_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wkts_datapath
// entry stores, key scan, saturating add, selection sort and result register
// ----------------------------------------------------------------------------
module wkts_datapath import wkts_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_rd_phase,  // memory read settling cycle
    input  wire logic [81:0]      i_item,
    output t_status               o_status,
    output logic [94:0]           o_result,
    output logic                  o_last
);
    logic [1:0]       r_act;
    logic [KEY_W-1:0] r_key;
    logic [WGT_W-1:0] r_win;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_i, r_j;
    logic [IDX_W-1:0] r_min;
    logic [KEY_W-1:0] r_mkey;
    logic [WGT_W-1:0] r_mwgt;
    logic             r_hit;
    logic [IDX_W-1:0] r_hidx;
    logic [94:0]      r_res;
    logic             r_last;
    logic [1:0]       r_swp;
    logic [KEY_W-1:0] r_ikey;
    logic [WGT_W-1:0] r_iwgt;

    logic             we;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] wkey, rkey;
    logic [WGT_W-1:0] wwgt, rwgt, sat;
    logic [WGT_W:0]   sum;
    logic             better;

    wkts_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_keys (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wkey), .o_rdata(rkey));
    wkts_ram #(.WIDTH(WGT_W), .DEPTH(CAPACITY)) u_wgts (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wwgt), .o_rdata(rwgt));

    assign sum = {rwgt[WGT_W-1], rwgt} + {r_win[WGT_W-1], r_win};
    always_comb begin
        if (sum[WGT_W] != sum[WGT_W-1]) begin
            sat = sum[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}};
        end else begin
            sat = sum[WGT_W-1:0];
        end
    end

    assign better = ($signed(rwgt) > $signed(r_mwgt)) ||
                    ((rwgt == r_mwgt) && ($signed(rkey) < $signed(r_mkey)));

    always_comb begin
        we   = 1'b0;
        addr = r_i[IDX_W-1:0];
        wkey = r_key;
        wwgt = r_win;
        case (i_cmd)
            CMD_SCAN: addr = r_i[IDX_W-1:0];
            CMD_WRITE: begin
                we = 1'b1;
                if (r_hit) begin
                    addr = r_hidx;
                    wwgt = sat;
                end else begin
                    addr = r_count[IDX_W-1:0];
                end
            end
            CMD_SORTSTP: addr = r_j[IDX_W-1:0];
            CMD_SORTSWP: begin
                // two writes: min entry to slot i, slot i entry to min slot
                we = ~i_rd_phase;
                if (r_swp == 2'd0) begin
                    addr = r_i[IDX_W-1:0];
                end else if (r_swp == 2'd1) begin
                    addr = r_i[IDX_W-1:0];
                    wkey = r_mkey;
                    wwgt = r_mwgt;
                end else begin
                    addr = r_min;
                    wkey = r_ikey;
                    wwgt = r_iwgt;
                end
                if (r_swp == 2'd0) begin
                    we = 1'b0;
                end
            end
            CMD_EMIT: addr = r_i[IDX_W-1:0];
            CMD_LOAD: addr = '0;
            // hit entry on the read port ahead of update or report
            default: addr = r_hit ? r_hidx : r_i[IDX_W-1:0];
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd == CMD_WRITE && !r_hit) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd == CMD_REPORT && r_act == ACT_CLEAR) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_act  <= i_item[1:0];
                r_key  <= i_item[33:2];
                r_win  <= i_item[81:34];
                r_hit  <= 1'b0;
                r_hidx <= '0;
                r_i    <= '0;
                r_j    <= '0;
                r_swp  <= 2'd0;
            end
            CMD_SCAN: begin
                if (i_rd_phase) begin
                    if (rkey == r_key && !r_hit) begin
                        r_hit  <= 1'b1;
                        r_hidx <= r_j[IDX_W-1:0];
                    end
                    r_j <= r_i;
                end else begin
                    r_j <= r_i;
                    r_i <= r_i + 1'b1;
                end
            end
            CMD_WRITE: begin
                r_res  <= {n_count, (r_hit ? r_hidx : r_count[IDX_W-1:0]),
                           (r_hit ? sat : r_win), r_key, r_hit, 1'b0};
                r_last <= 1'b1;
            end
            CMD_REPORT: begin
                if (r_act == ACT_CLEAR) begin
                    r_res <= '0;
                end else if (r_act == ACT_ADD) begin
                    r_res <= {r_count, {IDX_W{1'b0}}, {WGT_W{1'b0}}, r_key,
                              1'b0, 1'b1};
                end else if (r_hit) begin
                    r_res <= {r_count, r_hidx, rwgt, r_key, 1'b1, 1'b0};
                end else begin
                    r_res <= {r_count, {IDX_W{1'b0}}, {WGT_W{1'b0}}, r_key,
                              1'b0, 1'b0};
                end
                r_last <= 1'b1;
            end
            CMD_SORTSTP: begin
                // rd_phase: data of r_j valid; else addr r_j presented
                if (i_rd_phase) begin
                    if (r_j == r_i) begin
                        r_mkey <= rkey;
                        r_mwgt <= rwgt;
                        r_min  <= r_i[IDX_W-1:0];
                        r_ikey <= rkey;
                        r_iwgt <= rwgt;
                    end else if (better) begin
                        r_mkey <= rkey;
                        r_mwgt <= rwgt;
                        r_min  <= r_j[IDX_W-1:0];
                    end
                    r_j <= r_j + 1'b1;
                end
            end
            CMD_SORTSWP: begin
                if (!i_rd_phase) begin
                    if (r_swp == 2'd2) begin
                        r_swp <= 2'd0;
                        if (r_i + 2'd2 >= r_count) begin
                            r_i <= '0;
                            r_j <= '0;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_j <= r_i + 1'b1;
                        end
                    end else begin
                        r_swp <= r_swp + 1'b1;
                    end
                end
            end
            CMD_EMIT: begin
                if (i_rd_phase) begin
                    r_res  <= {r_count, r_i[IDX_W-1:0], rwgt, rkey, 2'b00};
                    r_last <= (r_i + 1'b1 == r_count);
                    r_i    <= r_i + 1'b1;
                end
            end
            default: begin
                if (r_act == ACT_SORT && r_j == '0 && r_i == '0) begin
                    r_j <= '0;
                end
            end
        endcase
    end

    assign o_status.hit        = r_hit;
    assign o_status.match      = (rkey == r_key);
    assign o_status.scan_done  = (r_i >= r_count);
    assign o_status.full       = (r_count == CNT_W'(CAPACITY));
    assign o_status.inner_done = (r_j + 1'b1 >= r_count);
    assign o_status.outer_done = (r_i + 1'b1 >= r_count);
    assign o_status.swap_done  = (r_swp == 2'd2);
    assign o_status.sort_done  = (r_i + 2'd2 >= r_count);
    assign o_status.emit_last  = (r_i >= r_count);
    assign o_status.empty      = (r_count == '0);
    assign o_status.action     = t_action'(r_act);
    assign o_result = r_res;
    assign o_last   = r_last;
endmodule
`default_nettype wire

[hw/rtl/wkts_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wkts_ctrl
// sequencer for scan, update, sort and emit phases with output handshake
// ----------------------------------------------------------------------------
module wkts_ctrl import wkts_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_rd_phase
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCAN  = 9'b000000010,
        ST_DEC   = 9'b000000100,
        ST_WRITE = 9'b000001000,
        ST_REP   = 9'b000010000,
        ST_SSTP  = 9'b000100000,
        ST_SSWP  = 9'b001000000,
        ST_EMIT  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ph, n_ph;
    logic   r_emitting, n_emitting;

    always_comb begin
        n_state    = r_state;
        n_ph       = r_ph;
        n_emitting = r_emitting;
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = ST_DEC;
                    n_ph    = 1'b0;
                end
            end
            ST_DEC: begin
                n_ph = 1'b0;
                case (i_status.action)
                    ACT_CLEAR: n_state = ST_REP;
                    ACT_SORT: begin
                        n_emitting = 1'b0;
                        if (i_status.empty) begin
                            n_state = ST_IDLE;
                        end else if (i_status.outer_done) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_SSTP;
                        end
                    end
                    default: n_state = i_status.empty ? ST_SCAN : ST_SCAN;
                endcase
            end
            ST_SCAN: begin
                o_cmd = CMD_SCAN;
                n_ph  = ~r_ph;
                if (r_ph && i_status.scan_done) begin
                    n_state = (i_status.action == ACT_ADD &&
                               (i_status.hit || i_status.match || !i_status.full)) ?
                              ST_WRITE : ST_REP;
                    n_ph = 1'b0;
                end else if (!r_ph && i_status.scan_done && !i_status.hit) begin
                    n_state = (i_status.action == ACT_ADD && !i_status.full) ?
                              ST_WRITE : ST_REP;
                end
                if (n_state == ST_REP && i_status.hit) begin
                    n_ph = 1'b0;
                end
            end
            ST_REP: begin
                // lookup hit needs the hit entry on the read port
                o_cmd = (r_ph || !i_status.hit || i_status.action != ACT_LOOKUP) ?
                        CMD_REPORT : CMD_NONE;
                n_ph  = 1'b1;
                if (o_cmd == CMD_REPORT) begin
                    n_state = ST_OUT;
                end
            end
            ST_WRITE: begin
                o_cmd = r_ph ? CMD_WRITE : CMD_NONE;
                n_ph  = 1'b1;
                if (r_ph) begin
                    n_state = ST_OUT;
                end
            end
            ST_SSTP: begin
                o_cmd = CMD_SORTSTP;
                n_ph  = ~r_ph;
                if (r_ph && i_status.inner_done) begin
                    n_state = ST_SSWP;
                    n_ph    = 1'b1;
                end
            end
            ST_SSWP: begin
                o_cmd = CMD_SORTSWP;
                n_ph  = 1'b0;
                if (!r_ph && i_status.swap_done) begin
                    n_state = i_status.sort_done ? ST_EMIT : ST_SSTP;
                end
            end
            ST_EMIT: begin
                o_cmd = CMD_EMIT;
                n_ph  = ~r_ph;
                if (r_ph) begin
                    n_state    = ST_OUT;
                    n_emitting = 1'b1;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_ph = 1'b0;
                    if (r_emitting && !i_status.emit_last) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state    = ST_IDLE;
                        n_emitting = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_rd_phase = r_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ph       <= 1'b0;
            r_emitting <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ph       <= n_ph;
            r_emitting <= n_emitting;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/wkts_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wkts_checker
// port-level checks of the tally unit
// ----------------------------------------------------------------------------
module wkts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && m_axis_tlast)
        else $error("full status with found");
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[92:86] <= 7'd64)
        else $error("entry total out of range");
endmodule

bind weighted_key_tally_sort_unit wkts_checker u_chk (.*);
`default_nettype wire
